FILE: hdl/midi_note_byte_parser_core_macros.svh
// ----------------------------------------------------------------------------
// MIDI note byte parser - assertion macros
// Shared concurrent assertion wrappers, clocked on the rising edge and
// disabled while reset is asserted.
// ----------------------------------------------------------------------------
`ifndef MIDI_NOTE_BYTE_PARSER_CORE_MACROS_SVH
`define MIDI_NOTE_BYTE_PARSER_CORE_MACROS_SVH

// Same-cycle implication: when ante holds, cons must hold in that cycle.
`define MNBP_ASSERT_SAME(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication: when ante holds, cons must hold in the next cycle.
`define MNBP_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hdl/mnbp_pkg.sv
// ----------------------------------------------------------------------------
// MIDI note byte parser - package
// Field widths, status codes, register indexes and the armed-state type.
// ----------------------------------------------------------------------------
`default_nettype none

package mnbp_pkg;

  // Payload field widths
  localparam int unsigned ValueW    = 10;
  localparam int unsigned PitchW    = 7;
  localparam int unsigned VelocityW = 7;
  localparam int unsigned ChannelW  = 5;
  localparam int unsigned NibbleW   = 4;

  // Configuration port
  localparam int unsigned CfgIdxW  = 1;
  localparam int unsigned CfgDataW = 5;

  typedef enum logic [CfgIdxW-1:0] {
    REG_MIDI_CHANNEL  = 1'b0,
    REG_RELATIVE_MODE = 1'b1
  } cfg_reg_e;

  // Upper nibble of the note status bytes
  localparam logic [NibbleW-1:0] STATUS_NOTE_OFF = 4'h8;
  localparam logic [NibbleW-1:0] STATUS_NOTE_ON  = 4'h9;

  // Midi channel register value that selects omni mode
  localparam logic [ChannelW-1:0] CHANNEL_OMNI = 5'd0;

  // What the last accepted note status armed
  typedef enum logic [1:0] {
    KIND_NONE = 2'd0,
    KIND_OFF  = 2'd1,
    KIND_ON   = 2'd2
  } armed_kind_e;

endpackage

`default_nettype wire

FILE: hdl/mnbp_in_if.sv
// ----------------------------------------------------------------------------
// MIDI note byte parser - input channel
// Valid/ready channel carrying one signed MIDI value per request.
// ----------------------------------------------------------------------------
`default_nettype none

interface mnbp_in_if;
  logic                                    valid;
  logic                                    ready;
  logic signed [mnbp_pkg::ValueW-1:0]      midi_value;

  modport source (output valid, output midi_value, input ready);
  modport sink   (input valid, input midi_value, output ready);
endinterface

`default_nettype wire

FILE: hdl/mnbp_out_if.sv
// ----------------------------------------------------------------------------
// MIDI note byte parser - result channel
// Valid/ready channel carrying one completed note message per request.
// ----------------------------------------------------------------------------
`default_nettype none

interface mnbp_out_if;
  logic                              valid;
  logic                              ready;
  logic [mnbp_pkg::PitchW-1:0]       note_pitch;
  logic [mnbp_pkg::VelocityW-1:0]    note_velocity;
  logic                              note_on;
  logic [mnbp_pkg::ChannelW-1:0]     note_channel;

  modport source (output valid, output note_pitch, output note_velocity,
                  output note_on, output note_channel, input ready);
  modport sink   (input valid, input note_pitch, input note_velocity,
                  input note_on, input note_channel, output ready);
endinterface

`default_nettype wire

FILE: hdl/midi_note_byte_parser_core.sv
// ----------------------------------------------------------------------------
// MIDI note byte parser - top level
// Note-on/note-off parser with running status over a MIDI byte stream.
// ----------------------------------------------------------------------------
// One request on midi_in carries one value; the block accepts one every
// clock cycle as long as the result side keeps up. A request is captured in
// an input register; once the result register is free, the parser state
// (armed kind, held pitch, heard channel) is updated and any completed note
// message is written into the result register and held there until taken.
// The update of that parser state sets the rate: one value per cycle while
// the result side keeps up. Negative values are ignored; values of 256 and
// above, non-note status bytes and note statuses on another channel clear
// the parser.
// Write configuration only while no request is in flight.
`default_nettype none

`include "midi_note_byte_parser_core_macros.svh"

module midi_note_byte_parser_core (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  mnbp_in_if.sink                                 midi_in,
  mnbp_out_if.source                              note_out,
  input  wire logic                               cfg_we_i,
  input  wire logic [mnbp_pkg::CfgIdxW-1:0]       cfg_idx_i,
  input  wire logic [mnbp_pkg::CfgDataW-1:0]      cfg_data_i
);

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [mnbp_pkg::ChannelW-1:0] midi_channel_q;
  logic                          relative_mode_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      midi_channel_q  <= mnbp_pkg::CHANNEL_OMNI;
      relative_mode_q <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        mnbp_pkg::REG_MIDI_CHANNEL:  midi_channel_q  <= cfg_data_i;
        mnbp_pkg::REG_RELATIVE_MODE: relative_mode_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Handshake: input register drains into the result register
  // --------------------------------------------------------------------------
  logic                                  in_valid_q;
  logic signed [mnbp_pkg::ValueW-1:0]    in_value_q;
  logic                                  out_valid_q;
  logic                                  out_free;
  logic                                  advance;
  logic                                  emit;

  assign out_free      = !out_valid_q || note_out.ready;
  assign advance       = in_valid_q && out_free;
  assign midi_in.ready = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (midi_in.ready) begin
      in_valid_q <= midi_in.valid;
    end
  end

  // payload needs no reset
  always_ff @(posedge clk_i) begin
    if (midi_in.valid && midi_in.ready) begin
      in_value_q <= midi_in.midi_value;
    end
  end

  // --------------------------------------------------------------------------
  // Decode of the held value
  // --------------------------------------------------------------------------
  logic                          is_negative;
  logic                          is_large;
  logic                          is_status;
  logic [mnbp_pkg::NibbleW-1:0]  status_hi;
  logic [mnbp_pkg::NibbleW-1:0]  status_chan;
  logic [mnbp_pkg::PitchW-1:0]   data_byte;
  logic                          is_note_status;
  logic                          omni;
  logic                          chan_match;

  assign is_negative    = in_value_q[mnbp_pkg::ValueW-1];
  assign is_large       = in_value_q[8];
  assign is_status      = in_value_q[7];
  assign status_hi      = in_value_q[7:4];
  assign status_chan    = in_value_q[3:0];
  assign data_byte      = in_value_q[6:0];
  assign is_note_status = (status_hi == mnbp_pkg::STATUS_NOTE_OFF) ||
                          (status_hi == mnbp_pkg::STATUS_NOTE_ON);
  assign omni           = (midi_channel_q == mnbp_pkg::CHANNEL_OMNI);
  assign chan_match     = ({1'b0, status_chan} + 5'd1) == midi_channel_q;

  // --------------------------------------------------------------------------
  // Parser state
  // --------------------------------------------------------------------------
  mnbp_pkg::armed_kind_e          kind_q, kind_d;
  logic                           pitch_held_q, pitch_held_d;
  logic [mnbp_pkg::PitchW-1:0]    held_pitch_q, held_pitch_d;
  logic [mnbp_pkg::NibbleW-1:0]   heard_chan_q, heard_chan_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kind_q       <= mnbp_pkg::KIND_NONE;
      pitch_held_q <= 1'b0;
      held_pitch_q <= '0;
      heard_chan_q <= '0;
    end else begin
      kind_q       <= kind_d;
      pitch_held_q <= pitch_held_d;
      held_pitch_q <= held_pitch_d;
      heard_chan_q <= heard_chan_d;
    end
  end

  // next state; a data byte with a held pitch completes a message
  always_comb begin
    kind_d       = kind_q;
    pitch_held_d = pitch_held_q;
    held_pitch_d = held_pitch_q;
    heard_chan_d = heard_chan_q;
    emit         = 1'b0;
    if (advance && !is_negative) begin
      priority if (is_large) begin
        kind_d       = mnbp_pkg::KIND_NONE;
        pitch_held_d = 1'b0;
      end else if (is_status) begin
        pitch_held_d = 1'b0;
        if (is_note_status && (omni || chan_match)) begin
          heard_chan_d = status_chan;
          kind_d       = (status_hi == mnbp_pkg::STATUS_NOTE_ON) ?
                         mnbp_pkg::KIND_ON : mnbp_pkg::KIND_OFF;
        end else begin
          kind_d = mnbp_pkg::KIND_NONE;
        end
      end else if (pitch_held_q) begin
        emit         = 1'b1;
        pitch_held_d = 1'b0;
      end else if (kind_q != mnbp_pkg::KIND_NONE) begin
        held_pitch_d = data_byte;
        pitch_held_d = 1'b1;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Result fields
  // --------------------------------------------------------------------------
  logic                            res_on;
  logic [mnbp_pkg::VelocityW-1:0]  res_velocity;
  logic [mnbp_pkg::ChannelW-1:0]   res_channel;

  assign res_on       = (kind_q == mnbp_pkg::KIND_ON) && (data_byte != '0);
  assign res_velocity = (relative_mode_q || res_on) ? data_byte : '0;
  assign res_channel  = omni ? ({1'b0, heard_chan_q} + 5'd1) : midi_channel_q;

  // --------------------------------------------------------------------------
  // Result register
  // --------------------------------------------------------------------------
  logic [mnbp_pkg::PitchW-1:0]     out_pitch_q;
  logic [mnbp_pkg::VelocityW-1:0]  out_velocity_q;
  logic                            out_on_q;
  logic [mnbp_pkg::ChannelW-1:0]   out_channel_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_pitch_q    <= held_pitch_q;
      out_velocity_q <= res_velocity;
      out_on_q       <= res_on;
      out_channel_q  <= res_channel;
    end
  end

  assign note_out.valid         = out_valid_q;
  assign note_out.note_pitch    = out_pitch_q;
  assign note_out.note_velocity = out_velocity_q;
  assign note_out.note_on       = out_on_q;
  assign note_out.note_channel  = out_channel_q;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  `MNBP_ASSERT_SAME(a_held_needs_armed, clk_i, rst_ni, pitch_held_q,
                    kind_q != mnbp_pkg::KIND_NONE, "pitch held while not armed")
  `MNBP_ASSERT_NEXT(a_emit_reaches_out, clk_i, rst_ni, emit, out_valid_q,
                    "completed message did not reach the result register")
  `MNBP_ASSERT_SAME(a_on_has_velocity, clk_i, rst_ni, out_valid_q && out_on_q,
                    out_velocity_q != '0, "note-on result with zero velocity")
  `MNBP_ASSERT_SAME(a_stall_only_full, clk_i, rst_ni, !midi_in.ready,
                    in_valid_q && out_valid_q, "input stalled with room free")

endmodule

`default_nettype wire
